// ===== hw/rtl/blake2b_hash_engine_macros.svh =====
// Assertion macros for the BLAKE2b engine.
// No dependencies; included by modules that carry assertions.
`ifndef BLAKE2B_HASH_ENGINE_MACROS_SVH
`define BLAKE2B_HASH_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define B2B_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define B2B_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("%m failed");
`else
`define B2B_ASSERT(label, clk, rst_n, prop)
`define B2B_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== hw/rtl/b2b_pkg.sv =====
// Constants and helpers for the BLAKE2b engine.
// No dependencies.
package b2b_pkg;
    typedef logic [63:0] word_t;

    localparam word_t IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [1:0] REG_DIGEST_LENGTH = 2'd0;
    localparam logic [1:0] REG_KEY_LENGTH    = 2'd1;

    // message word index for round r (mod 10), position p; nibble p of the row
    function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] p);
        logic [63:0] row;
        unique case (r)
            4'd0:    row = 64'hfedcba9876543210;
            4'd1:    row = 64'h357b20c16df984ae;
            4'd2:    row = 64'h491763eadf250c8b;
            4'd3:    row = 64'h8f04a562ebcd1397;
            4'd4:    row = 64'hd386cb1efa427509;
            4'd5:    row = 64'h91ef57d438b0a6c2;
            4'd6:    row = 64'hb8293670a4def15c;
            4'd7:    row = 64'ha2684f05931ce7bd;
            4'd8:    row = 64'h5a417d2c803b9ef6;
            4'd9:    row = 64'h0dc3e9bf5167482a;
            default: row = 64'hfedcba9876543210;
        endcase
        return row[{p, 2'b00} +: 4];
    endfunction
endpackage

// ===== hw/rtl/b2b_stream_if.sv =====
// Valid/ready stream interface with a typed payload.
// Depends on nothing; payload type given as a parameter.
interface b2b_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/blake2b_hash_engine.sv =====
// Sequential BLAKE2b top level with one shared G-function datapath.
// Depends on b2b_pkg, b2b_stream_if and blake2b_hash_engine_macros.svh.
//
// channel  | dir | payload
// in_s     | in  | message_word[63:0], byte_count[3:0], last_word
// out_s    | out | digest_word[63:0], digest_bytes[3:0], last_result
// cfg      | in  | cfg_we, cfg_index[1:0], cfg_data[6:0]
//
// A word is accepted whenever the engine is idle. A word arriving on a full block starts a
// compression and holds the input off through the setup state, 192 half-G steps (12 rounds x
// 8 G x 2 halves) on one adder/rotate datapath, and the chain update.
// The last word adds one compression (two if it opens a new block), then
// ceil(digest_length/8) digest words go out, one per cycle while out_s.ready.
// Reset restores the IV chain for 64-byte unkeyed digests; output stalls hold the engine.
`include "blake2b_hash_engine_macros.svh"
module blake2b_hash_engine
    import b2b_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [6:0] cfg_data,
    b2b_stream_if.sink   in_s,
    b2b_stream_if.source out_s
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MIX  = 3'd1;
    localparam logic [2:0] ST_FIN  = 3'd2;
    localparam logic [2:0] ST_OUT  = 3'd3;
    localparam logic [2:0] ST_XOR  = 3'd4;

    logic [2:0]   st_reg;
    logic [6:0]   dlen_cfg_reg, klen_cfg_reg, dlen_reg;
    logic         in_msg_reg, final_reg;
    word_t        h_reg [8];
    word_t        m_reg [16];
    word_t        v_reg [16];
    logic [127:0] cnt_reg;
    logic [4:0]   held_reg;
    logic [3:0]   tail_reg;
    logic [3:0]   rnd_reg;
    logic [2:0]   gi_reg;
    logic         ph_reg;
    logic [2:0]   ok_reg;
    logic         pend_reg;
    word_t        pw_reg;
    logic         plast_reg;

    word_t w_in;
    logic [3:0] nb_in;
    logic last_in;
    assign w_in    = in_s.data.message_word;
    assign nb_in   = in_s.data.byte_count;
    assign last_in = in_s.data.last_word;

    logic [6:0] dl_c, kl_c;
    assign dl_c = (dlen_cfg_reg == 7'd0) ? 7'd1 : (dlen_cfg_reg > 7'd64 ? 7'd64 : dlen_cfg_reg);
    assign kl_c = (klen_cfg_reg > 7'd64) ? 7'd64 : klen_cfg_reg;

    // lane selection
    logic [3:0] ia, ib, ic, id;
    always_comb
    begin
        if (!gi_reg[2])
        begin
            ia = {2'b00, gi_reg[1:0]};
            ib = {2'b01, gi_reg[1:0]};
            ic = {2'b10, gi_reg[1:0]};
            id = {2'b11, gi_reg[1:0]};
        end
        else
        begin
            ia = {2'b00, gi_reg[1:0]};
            ib = {2'b01, gi_reg[1:0] + 2'd1};
            ic = {2'b10, gi_reg[1:0] + 2'd2};
            id = {2'b11, gi_reg[1:0] + 2'd3};
        end
    end

    // half of a G step: rotations 32/24 in the first half, 16/63 in the second
    logic [3:0] rmod;
    assign rmod = (rnd_reg >= 4'd10) ? rnd_reg - 4'd10 : rnd_reg;
    word_t hm, ha, hdx, hd, hc, hbx, hb;
    always_comb
    begin
        hm  = m_reg[sigma(rmod, {gi_reg, ph_reg})];
        ha  = v_reg[ia] + v_reg[ib] + hm;
        hdx = v_reg[id] ^ ha;
        hd  = ph_reg ? {hdx[15:0], hdx[63:16]} : {hdx[31:0], hdx[63:32]};
        hc  = v_reg[ic] + hd;
        hbx = v_reg[ib] ^ hc;
        hb  = ph_reg ? {hbx[62:0], hbx[63]} : {hbx[23:0], hbx[63:24]};
    end

    logic [127:0] fin_add;
    assign fin_add = (held_reg == 5'd0) ? 128'd0
                   : {120'd0, held_reg - 5'd1, 3'd0} + {124'd0, tail_reg};

    logic [6:0] rem;
    assign rem = dlen_reg - {1'b0, ok_reg, 3'd0};

    assign in_s.ready  = (st_reg == ST_IDLE) && !out_s.valid;
    assign out_s.valid = (st_reg == ST_OUT);
    assign out_s.data.digest_word  = h_reg[ok_reg];
    assign out_s.data.digest_bytes = (rem > 7'd8) ? 4'd8 : rem[3:0];
    assign out_s.data.last_result  = (rem <= 7'd8);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_IDLE;
            dlen_cfg_reg <= 7'd64;
            klen_cfg_reg <= 7'd0;
            dlen_reg     <= 7'd64;
            in_msg_reg   <= 1'b0;
            final_reg    <= 1'b0;
            cnt_reg      <= '0;
            held_reg     <= '0;
            tail_reg     <= '0;
            rnd_reg      <= '0;
            gi_reg       <= '0;
            ph_reg       <= 1'b0;
            ok_reg       <= '0;
            pend_reg     <= 1'b0;
            pw_reg       <= '0;
            plast_reg    <= 1'b0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= (i == 0) ? (IV[0] ^ 64'h01010040) : IV[i];
            for (int i = 0; i < 16; i++)
            begin
                m_reg[i] <= '0;
                v_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we && cfg_index == REG_DIGEST_LENGTH) dlen_cfg_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_KEY_LENGTH)    klen_cfg_reg <= cfg_data;
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (in_s.valid && in_s.ready)
                    begin
                        logic [3:0]   nb;
                        logic [4:0]   held;
                        logic [3:0]   tail;
                        logic [127:0] cnt;
                        word_t        wm;
                        nb = (!last_in || nb_in > 4'd8) ? 4'd8 : nb_in;
                        wm = (nb == 4'd8) ? w_in : (w_in & ((64'd1 << {nb, 3'd0}) - 64'd1));
                        held = in_msg_reg ? held_reg : 5'd0;
                        tail = in_msg_reg ? tail_reg : 4'd0;
                        cnt  = in_msg_reg ? cnt_reg : 128'd0;
                        if (!in_msg_reg)
                        begin
                            dlen_reg <= dl_c;
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= (i == 0) ? (IV[0] ^ {32'd0, 8'h01, 8'h01,
                                            1'b0, kl_c, 1'b0, dl_c}) : IV[i];
                        end
                        in_msg_reg <= !last_in;
                        if (nb != 4'd0 && held == 5'd16)
                        begin
                            pend_reg  <= 1'b1;
                            pw_reg    <= wm;
                            plast_reg <= last_in;
                            tail      = nb;
                            cnt       = cnt + 128'd128;
                            final_reg <= 1'b0;
                            st_reg    <= ST_FIN;
                        end
                        else
                        begin
                            if (nb != 4'd0)
                            begin
                                m_reg[held[3:0]] <= wm;
                                held = held + 5'd1;
                                tail = nb;
                            end
                            if (last_in)
                            begin
                                pend_reg <= 1'b0;
                                plast_reg <= 1'b1;
                                st_reg <= ST_FIN;
                                final_reg <= 1'b1;
                            end
                        end
                        held_reg <= held;
                        tail_reg <= tail;
                        cnt_reg  <= cnt;
                    end
                end
                ST_FIN:
                begin
                    // set up working vector
                    logic [127:0] c;
                    c = final_reg ? cnt_reg + fin_add : cnt_reg;
                    if (final_reg) cnt_reg <= c;
                    for (int i = 0; i < 8; i++)
                        v_reg[i] <= h_reg[i];
                    v_reg[8]  <= IV[0];
                    v_reg[9]  <= IV[1];
                    v_reg[10] <= IV[2];
                    v_reg[11] <= IV[3];
                    v_reg[12] <= IV[4] ^ c[63:0];
                    v_reg[13] <= IV[5] ^ c[127:64];
                    v_reg[14] <= final_reg ? ~IV[6] : IV[6];
                    v_reg[15] <= IV[7];
                    rnd_reg <= '0;
                    gi_reg  <= '0;
                    ph_reg  <= 1'b0;
                    st_reg  <= ST_MIX;
                end
                ST_MIX:
                begin
                    v_reg[ia] <= ha;
                    v_reg[ib] <= hb;
                    v_reg[ic] <= hc;
                    v_reg[id] <= hd;
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        gi_reg <= gi_reg + 3'd1;
                        if (gi_reg == 3'd7)
                        begin
                            rnd_reg <= rnd_reg + 4'd1;
                            if (rnd_reg == 4'd11) st_reg <= ST_XOR;
                        end
                    end
                end
                ST_XOR:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] ^ v_reg[i] ^ v_reg[i+8];
                    if (pend_reg)
                    begin
                        for (int i = 0; i < 16; i++)
                            m_reg[i] <= (i == 0) ? pw_reg : 64'd0;
                        held_reg <= 5'd1;
                        pend_reg <= 1'b0;
                        if (plast_reg)
                        begin
                            final_reg <= 1'b1;
                            st_reg <= ST_FIN;
                        end
                        else
                        begin
                            st_reg <= ST_IDLE;
                        end
                    end
                    else if (final_reg)
                    begin
                        for (int i = 0; i < 16; i++)
                            m_reg[i] <= '0;
                        ok_reg <= '0;
                        st_reg <= ST_OUT;
                    end
                    else
                    begin
                        st_reg <= ST_IDLE;
                    end
                end
                ST_OUT:
                begin
                    if (out_s.ready)
                    begin
                        ok_reg <= ok_reg + 3'd1;
                        if (rem <= 7'd8)
                        begin
                            st_reg <= ST_IDLE;
                            held_reg <= '0;
                        end
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    `B2B_ASSERT(a_out_only_final, clk, rst_n, out_s.valid |-> final_reg)
    `B2B_ASSERT(a_held_range, clk, rst_n, held_reg <= 5'd16)
    `B2B_ASSERT_NEVER(a_ready_while_out, clk, rst_n, in_s.ready && out_s.valid)
endmodule
